// File: design/gaas_pkg.sv
`timescale 1ns / 1ps

package gaas_pkg;

    localparam int COORD_W = 8;
    localparam int EXT_W   = 9;
    localparam int HEAD_W  = 3;
    localparam int IDX_W   = 3;
    localparam int CFG_W   = 9;

    localparam logic OP_STEP = 1'b0;
    localparam logic OP_LOAD = 1'b1;

    localparam logic [IDX_W-1:0] REG_GRID_ROWS     = 3'd0;
    localparam logic [IDX_W-1:0] REG_GRID_COLS     = 3'd1;
    localparam logic [IDX_W-1:0] REG_START_ROW     = 3'd2;
    localparam logic [IDX_W-1:0] REG_START_COL     = 3'd3;
    localparam logic [IDX_W-1:0] REG_START_HEADING = 3'd4;

    localparam logic [HEAD_W-1:0] HEAD_E    = 3'd0;
    localparam logic [HEAD_W-1:0] HEAD_NE   = 3'd1;
    localparam logic [HEAD_W-1:0] HEAD_N    = 3'd2;
    localparam logic [HEAD_W-1:0] HEAD_NW   = 3'd3;
    localparam logic [HEAD_W-1:0] HEAD_WEST = 3'd4;
    localparam logic [HEAD_W-1:0] HEAD_SW   = 3'd5;
    localparam logic [HEAD_W-1:0] HEAD_S    = 3'd6;
    localparam logic [HEAD_W-1:0] HEAD_SE   = 3'd7;

    localparam logic [HEAD_W-1:0] TURN_WHITE = 3'd2;
    localparam logic [HEAD_W-1:0] TURN_BLACK = 3'd6;

    localparam logic [EXT_W-1:0] GRID_RESET = 9'd256;

    typedef enum logic [1:0] {
        ST_CLEAR,
        ST_IDLE,
        ST_EXEC,
        ST_MOD
    } t_state;

    typedef struct packed {
        logic             start;
        logic [EXT_W-1:0] x;
        logic [EXT_W-1:0] d;
    } t_mod_req;

    typedef struct packed {
        logic               done;
        logic [COORD_W-1:0] rem;
    } t_mod_rsp;

endpackage

// File: design/grid_ant_automaton_step_unit.sv
`timescale 1ns / 1ps

// A step request passes from idle into the execute state, which registers its result strobe, and the next
// request may start in the cycle of that strobe; when the ant sits outside the extent in
// use the wrap goes through a bit-serial remainder unit in the remainder state before the strobe.
// A load request gives its strobe in the cycle after start is taken and never raises busy.
// After reset the grid memory is cleared to white one cell a cycle, over all
// 2**(clog2(min(MAX_ROWS,256)) + clog2(min(MAX_COLS,256))) cells, while busy stays high.
module grid_ant_automaton_step_unit
    import gaas_pkg::*;
#(
    parameter int MAX_ROWS = 256,
    parameter int MAX_COLS = 256
) (
    input  logic               i_clk,
    input  logic               i_rst_n,
    input  logic               start,
    output logic               busy,
    input  logic               i_op,
    input  logic [COORD_W-1:0] i_load_row,
    input  logic [COORD_W-1:0] i_load_col,
    input  logic               i_load_colour,
    output logic               o_strobe,
    output logic [COORD_W-1:0] o_ant_row,
    output logic [COORD_W-1:0] o_ant_col,
    output logic [HEAD_W-1:0]  o_ant_heading,
    output logic               o_colour_seen,
    input  logic               i_cfg_valid,
    output logic               o_cfg_ready,
    input  logic [IDX_W-1:0]   i_cfg_index,
    input  logic [CFG_W-1:0]   i_cfg_data
);

    localparam int ROWS_ST = (MAX_ROWS < 256) ? MAX_ROWS : 256;
    localparam int COLS_ST = (MAX_COLS < 256) ? MAX_COLS : 256;
    localparam int RW      = $clog2(ROWS_ST);
    localparam int CW      = $clog2(COLS_ST);
    localparam int AW      = RW + CW;
    localparam logic [EXT_W-1:0] ROWS_LIM = EXT_W'(ROWS_ST);
    localparam logic [EXT_W-1:0] COLS_LIM = EXT_W'(COLS_ST);

    t_state r_state;
    t_state n_state;

    logic [AW-1:0]      r_clr_addr;
    logic [EXT_W-1:0]   r_grid_rows;
    logic [EXT_W-1:0]   r_grid_cols;
    logic [COORD_W-1:0] r_pos_row;
    logic [COORD_W-1:0] r_pos_col;
    logic [HEAD_W-1:0]  r_heading;
    logic               r_slow_row;
    logic               r_slow_col;
    logic               r_out_valid;
    logic [COORD_W-1:0] r_out_row;
    logic [COORD_W-1:0] r_out_col;
    logic [HEAD_W-1:0]  r_out_heading;
    logic               r_out_seen;

    logic               accept;
    logic [EXT_W-1:0]   ext_row;
    logic [EXT_W-1:0]   ext_col;
    logic               pos_in_store;
    logic               load_in_store;
    logic [AW-1:0]      pos_addr;
    logic [AW-1:0]      load_addr;
    logic               mem_rdata;
    logic               seen;
    logic [HEAD_W-1:0]  new_head;
    logic               row_inc;
    logic               row_dec;
    logic               col_inc;
    logic               col_dec;
    logic [EXT_W-1:0]   row_x;
    logic [EXT_W-1:0]   col_x;
    logic [EXT_W-1:0]   row_wrap;
    logic [EXT_W-1:0]   col_wrap;
    logic               row_slow;
    logic               col_slow;
    logic [COORD_W-1:0] row_next;
    logic [COORD_W-1:0] col_next;

    logic               mem_we;
    logic [AW-1:0]      mem_waddr;
    logic               mem_wdata;
    logic               mem_re;

    t_mod_req row_req;
    t_mod_req col_req;
    t_mod_rsp row_rsp;
    t_mod_rsp col_rsp;

    assign accept = start && !busy;

    always_comb begin
        if (r_grid_rows == '0) begin
            ext_row = EXT_W'(1);
        end else if (r_grid_rows > ROWS_LIM) begin
            ext_row = ROWS_LIM;
        end else begin
            ext_row = r_grid_rows;
        end
        if (r_grid_cols == '0) begin
            ext_col = EXT_W'(1);
        end else if (r_grid_cols > COLS_LIM) begin
            ext_col = COLS_LIM;
        end else begin
            ext_col = r_grid_cols;
        end
    end

    always_comb begin
        pos_in_store  = ({1'b0, r_pos_row} < ROWS_LIM) && ({1'b0, r_pos_col} < COLS_LIM);
        load_in_store = ({1'b0, i_load_row} < ROWS_LIM) && ({1'b0, i_load_col} < COLS_LIM);
        pos_addr      = {r_pos_row[RW-1:0], r_pos_col[CW-1:0]};
        load_addr     = {i_load_row[RW-1:0], i_load_col[CW-1:0]};
        seen          = mem_rdata && pos_in_store;
        new_head      = r_heading + (seen ? TURN_BLACK : TURN_WHITE);
    end

    always_comb begin
        row_dec = (new_head == HEAD_NE) || (new_head == HEAD_N) || (new_head == HEAD_NW);
        row_inc = (new_head == HEAD_SW) || (new_head == HEAD_S) || (new_head == HEAD_SE);
        col_inc = (new_head == HEAD_E) || (new_head == HEAD_NE) || (new_head == HEAD_SE);
        col_dec = (new_head == HEAD_NW) || (new_head == HEAD_WEST) || (new_head == HEAD_SW);

        row_x = row_inc ? ({1'b0, r_pos_row} + EXT_W'(1))
                        : ({1'b0, r_pos_row} + ext_row - EXT_W'(1));
        col_x = col_inc ? ({1'b0, r_pos_col} + EXT_W'(1))
                        : ({1'b0, r_pos_col} + ext_col - EXT_W'(1));

        row_wrap = (row_x >= ext_row) ? (row_x - ext_row) : row_x;
        col_wrap = (col_x >= ext_col) ? (col_x - ext_col) : col_x;

        row_slow = (row_inc || row_dec) && ({1'b0, r_pos_row} >= ext_row);
        col_slow = (col_inc || col_dec) && ({1'b0, r_pos_col} >= ext_col);

        row_next = (row_inc || row_dec) ? row_wrap[COORD_W-1:0] : r_pos_row;
        col_next = (col_inc || col_dec) ? col_wrap[COORD_W-1:0] : r_pos_col;
    end

    always_comb begin
        row_req.start = (r_state == ST_EXEC) && (row_slow || col_slow);
        row_req.x     = row_x;
        row_req.d     = ext_row;
        col_req.start = row_req.start;
        col_req.x     = col_x;
        col_req.d     = ext_col;
    end

    always_comb begin
        n_state = r_state;
        case (r_state)
            ST_CLEAR: begin
                if (r_clr_addr == '1) begin
                    n_state = ST_IDLE;
                end
            end
            ST_IDLE: begin
                if (accept && (i_op == OP_STEP)) begin
                    n_state = ST_EXEC;
                end
            end
            ST_EXEC: begin
                if (row_slow || col_slow) begin
                    n_state = ST_MOD;
                end else begin
                    n_state = ST_IDLE;
                end
            end
            ST_MOD: begin
                if (row_rsp.done) begin
                    n_state = ST_IDLE;
                end
            end
            default: begin
                n_state = ST_CLEAR;
            end
        endcase
    end

    always_comb begin
        busy      = 1'b1;
        mem_we    = 1'b0;
        mem_waddr = pos_addr;
        mem_wdata = 1'b0;
        mem_re    = 1'b0;
        case (r_state)
            ST_CLEAR: begin
                mem_we    = 1'b1;
                mem_waddr = r_clr_addr;
            end
            ST_IDLE: begin
                busy      = 1'b0;
                mem_we    = accept && (i_op == OP_LOAD) && load_in_store;
                mem_waddr = load_addr;
                mem_wdata = i_load_colour;
                mem_re    = accept && (i_op == OP_STEP);
            end
            ST_EXEC: begin
                mem_we    = pos_in_store;
                mem_wdata = !seen;
            end
            ST_MOD: begin
                mem_we = 1'b0;
            end
            default: begin
                busy = 1'b1;
            end
        endcase
    end

    gaas_grid_mem #(
        .AW(AW)
    ) u_grid_mem (
        .i_clk   (i_clk),
        .i_we    (mem_we),
        .i_waddr (mem_waddr),
        .i_wdata (mem_wdata),
        .i_re    (mem_re),
        .i_raddr (pos_addr),
        .o_rdata (mem_rdata)
    );

    gaas_mod_unit u_mod_row (
        .i_clk   (i_clk),
        .i_rst_n (i_rst_n),
        .i_req   (row_req),
        .o_rsp   (row_rsp)
    );

    gaas_mod_unit u_mod_col (
        .i_clk   (i_clk),
        .i_rst_n (i_rst_n),
        .i_req   (col_req),
        .o_rsp   (col_rsp)
    );

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state     <= ST_CLEAR;
            r_clr_addr  <= '0;
            r_grid_rows <= GRID_RESET;
            r_grid_cols <= GRID_RESET;
            r_pos_row   <= '0;
            r_pos_col   <= '0;
            r_heading   <= HEAD_E;
            r_slow_row  <= 1'b0;
            r_slow_col  <= 1'b0;
            r_out_valid <= 1'b0;
        end else begin
            r_state     <= n_state;
            r_out_valid <= 1'b0;
            if (r_state == ST_CLEAR) begin
                r_clr_addr <= r_clr_addr + AW'(1);
            end
            if (i_cfg_valid) begin
                case (i_cfg_index)
                    REG_GRID_ROWS:     r_grid_rows <= i_cfg_data;
                    REG_GRID_COLS:     r_grid_cols <= i_cfg_data;
                    REG_START_ROW:     r_pos_row   <= i_cfg_data[COORD_W-1:0];
                    REG_START_COL:     r_pos_col   <= i_cfg_data[COORD_W-1:0];
                    REG_START_HEADING: r_heading   <= i_cfg_data[HEAD_W-1:0];
                    default: begin
                    end
                endcase
            end
            if ((r_state == ST_IDLE) && accept && (i_op == OP_LOAD)) begin
                r_out_valid <= 1'b1;
            end
            if (r_state == ST_EXEC) begin
                r_heading  <= new_head;
                r_pos_row  <= row_next;
                r_pos_col  <= col_next;
                r_slow_row <= row_slow;
                r_slow_col <= col_slow;
                if (!(row_slow || col_slow)) begin
                    r_out_valid <= 1'b1;
                end
            end
            if ((r_state == ST_MOD) && row_rsp.done) begin
                r_out_valid <= 1'b1;
                if (r_slow_row) begin
                    r_pos_row <= row_rsp.rem;
                end
                if (r_slow_col) begin
                    r_pos_col <= col_rsp.rem;
                end
            end
        end
    end

    always_ff @(posedge i_clk) begin
        case (r_state)
            ST_IDLE: begin
                if (accept && (i_op == OP_LOAD)) begin
                    r_out_row     <= r_pos_row;
                    r_out_col     <= r_pos_col;
                    r_out_heading <= r_heading;
                    r_out_seen    <= 1'b0;
                end
            end
            ST_EXEC: begin
                r_out_row     <= row_next;
                r_out_col     <= col_next;
                r_out_heading <= new_head;
                r_out_seen    <= seen;
            end
            ST_MOD: begin
                if (row_rsp.done && r_slow_row) begin
                    r_out_row <= row_rsp.rem;
                end
                if (row_rsp.done && r_slow_col) begin
                    r_out_col <= col_rsp.rem;
                end
            end
            default: begin
            end
        endcase
    end

    assign o_strobe      = r_out_valid;
    assign o_ant_row     = r_out_row;
    assign o_ant_col     = r_out_col;
    assign o_ant_heading = r_out_heading;
    assign o_colour_seen = r_out_seen;
    assign o_cfg_ready   = 1'b1;

    a_step_enters_exec: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (accept && (i_op == OP_STEP)) |=> (r_state == ST_EXEC))
        else $error("step request did not enter execute");

    a_no_result_while_clearing: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (r_state == ST_CLEAR) |-> !o_strobe)
        else $error("result strobe during clearing pass");

    a_mod_units_lockstep: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        row_rsp.done |-> col_rsp.done)
        else $error("row and column remainder units out of step");

endmodule

// File: design/gaas_grid_mem.sv
`timescale 1ns / 1ps

module gaas_grid_mem #(
    parameter int AW = 16
) (
    input  logic          i_clk,
    input  logic          i_we,
    input  logic [AW-1:0] i_waddr,
    input  logic          i_wdata,
    input  logic          i_re,
    input  logic [AW-1:0] i_raddr,
    output logic          o_rdata
);

    logic mem [0:(2**AW)-1];
    logic r_rdata;

    always_ff @(posedge i_clk) begin
        if (i_we) begin
            mem[i_waddr] <= i_wdata;
        end
        if (i_re) begin
            r_rdata <= mem[i_raddr];
        end
    end

    assign o_rdata = r_rdata;

endmodule

// File: design/gaas_mod_unit.sv
`timescale 1ns / 1ps

module gaas_mod_unit
    import gaas_pkg::*;
(
    input  logic     i_clk,
    input  logic     i_rst_n,
    input  t_mod_req i_req,
    output t_mod_rsp o_rsp
);

    localparam int CNT_W = $clog2(EXT_W + 1);

    logic [EXT_W-1:0] r_x;
    logic [EXT_W-1:0] r_d;
    logic [EXT_W-1:0] r_rem;
    logic [CNT_W-1:0] r_cnt;
    logic             r_done;
    logic [EXT_W-1:0] shifted;
    logic [EXT_W-1:0] trial;

    always_comb begin
        shifted = {r_rem[EXT_W-2:0], r_x[EXT_W-1]};
        trial   = (shifted >= r_d) ? (shifted - r_d) : shifted;
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_cnt  <= '0;
            r_done <= 1'b0;
        end else begin
            r_done <= 1'b0;
            if (i_req.start) begin
                r_cnt <= CNT_W'(EXT_W);
            end else if (r_cnt != '0) begin
                r_cnt <= r_cnt - CNT_W'(1);
                if (r_cnt == CNT_W'(1)) begin
                    r_done <= 1'b1;
                end
            end
        end
    end

    always_ff @(posedge i_clk) begin
        if (i_req.start) begin
            r_x   <= i_req.x;
            r_d   <= i_req.d;
            r_rem <= '0;
        end else if (r_cnt != '0) begin
            r_x   <= {r_x[EXT_W-2:0], 1'b0};
            r_rem <= trial;
        end
    end

    assign o_rsp.done = r_done;
    assign o_rsp.rem  = r_rem[COORD_W-1:0];

    a_rem_below_divisor: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        r_done |-> (r_rem < r_d))
        else $error("remainder not below divisor");

    a_done_after_last_step: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        r_done |-> ($past(r_cnt) == CNT_W'(1)))
        else $error("done without final iteration");

endmodule

// File: tb/sv/grid_ant_automaton_step_unit_tb.sv
`timescale 1ns / 1ps

module grid_ant_automaton_step_unit_tb;
    import gaas_pkg::*;

    localparam int GRID_MAX_ROWS   = 256;
    localparam int GRID_MAX_COLS   = 256;
    localparam int PHASES          = 10;
    localparam int ITEMS_PER_PHASE = 103;
    localparam int SETTLE_CYCLES   = 12;
    localparam int WATCHDOG_LIMIT  = 200000;
    localparam int PLAN_LEN        = 43;

    localparam logic [IDX_W-1:0] REG_SPARE_FIRST = 3'd5;
    localparam logic [IDX_W-1:0] REG_SPARE_LAST  = 3'd7;

    typedef struct packed {
        logic [COORD_W-1:0] row;
        logic [COORD_W-1:0] col;
        logic [HEAD_W-1:0]  heading;
        logic               seen;
    } t_ant_report;

    typedef enum logic {
        PLAN_ITEM,
        PLAN_CFG
    } t_plan_kind;

    typedef struct packed {
        t_plan_kind         kind;
        logic               op;
        logic [COORD_W-1:0] row;
        logic [COORD_W-1:0] col;
        logic               colour;
        logic [IDX_W-1:0]   reg_idx;
        logic [CFG_W-1:0]   reg_data;
        logic               typed;
        t_ant_report        want;
    } t_plan_row;

    localparam t_ant_report NO_REPORT = '0;

    localparam t_plan_row DIRECTED_PLAN [PLAN_LEN] = '{
        '{PLAN_ITEM, OP_STEP, 8'd0, 8'd0, 1'b0, REG_GRID_ROWS, 9'd0, 1'b1,
          '{8'd255, 8'd0, HEAD_N, 1'b0}},
        '{PLAN_ITEM, OP_STEP, 8'd0, 8'd0, 1'b0, REG_GRID_ROWS, 9'd0, 1'b1,
          '{8'd255, 8'd255, HEAD_WEST, 1'b0}},
        '{PLAN_ITEM, OP_LOAD, 8'd255, 8'd255, 1'b1, REG_GRID_ROWS, 9'd0, 1'b1,
          '{8'd255, 8'd255, HEAD_WEST, 1'b0}},
        '{PLAN_ITEM, OP_STEP, 8'd0, 8'd0, 1'b0, REG_GRID_ROWS, 9'd0, 1'b1,
          '{8'd254, 8'd255, HEAD_N, 1'b1}},
        '{PLAN_ITEM, OP_LOAD, 8'd0, 8'd0, 1'b1, REG_GRID_ROWS, 9'd0, 1'b1,
          '{8'd254, 8'd255, HEAD_N, 1'b0}},
        '{PLAN_ITEM, OP_LOAD, 8'd170, 8'd85, 1'b1, REG_GRID_ROWS, 9'd0, 1'b0, NO_REPORT},
        '{PLAN_ITEM, OP_LOAD, 8'd85, 8'd170, 1'b0, REG_GRID_ROWS, 9'd0, 1'b0, NO_REPORT},
        '{PLAN_CFG, OP_STEP, 8'd0, 8'd0, 1'b0, REG_GRID_ROWS, 9'd0, 1'b0, NO_REPORT},
        '{PLAN_CFG, OP_STEP, 8'd0, 8'd0, 1'b0, REG_GRID_COLS, 9'd0, 1'b0, NO_REPORT},
        '{PLAN_CFG, OP_STEP, 8'd0, 8'd0, 1'b0, REG_START_ROW, 9'h1FF, 1'b0, NO_REPORT},
        '{PLAN_CFG, OP_STEP, 8'd0, 8'd0, 1'b0, REG_START_COL, 9'h1AA, 1'b0, NO_REPORT},
        '{PLAN_CFG, OP_STEP, 8'd0, 8'd0, 1'b0, REG_START_HEADING, 9'h1FD, 1'b0, NO_REPORT},
        '{PLAN_CFG, OP_STEP, 8'd0, 8'd0, 1'b0, REG_SPARE_FIRST, 9'h1FF, 1'b0, NO_REPORT},
        '{PLAN_CFG, OP_STEP, 8'd0, 8'd0, 1'b0, REG_SPARE_LAST, 9'd0, 1'b0, NO_REPORT},
        '{PLAN_ITEM, OP_STEP, 8'd0, 8'd0, 1'b0, REG_GRID_ROWS, 9'd0, 1'b0, NO_REPORT},
        '{PLAN_ITEM, OP_STEP, 8'd0, 8'd0, 1'b0, REG_GRID_ROWS, 9'd0, 1'b0, NO_REPORT},
        '{PLAN_ITEM, OP_STEP, 8'd0, 8'd0, 1'b0, REG_GRID_ROWS, 9'd0, 1'b0, NO_REPORT},
        '{PLAN_CFG, OP_STEP, 8'd0, 8'd0, 1'b0, REG_GRID_ROWS, 9'h1FF, 1'b0, NO_REPORT},
        '{PLAN_CFG, OP_STEP, 8'd0, 8'd0, 1'b0, REG_GRID_COLS, 9'd3, 1'b0, NO_REPORT},
        '{PLAN_CFG, OP_STEP, 8'd0, 8'd0, 1'b0, REG_START_ROW, 9'd1, 1'b0, NO_REPORT},
        '{PLAN_CFG, OP_STEP, 8'd0, 8'd0, 1'b0, REG_START_COL, 9'd2, 1'b0, NO_REPORT},
        '{PLAN_CFG, OP_STEP, 8'd0, 8'd0, 1'b0, REG_START_HEADING, 9'd7, 1'b0, NO_REPORT},
        '{PLAN_ITEM, OP_LOAD, 8'd200, 8'd200, 1'b1, REG_GRID_ROWS, 9'd0, 1'b0, NO_REPORT},
        '{PLAN_ITEM, OP_STEP, 8'd0, 8'd0, 1'b0, REG_GRID_ROWS, 9'd0, 1'b0, NO_REPORT},
        '{PLAN_ITEM, OP_STEP, 8'd0, 8'd0, 1'b0, REG_GRID_ROWS, 9'd0, 1'b0, NO_REPORT},
        '{PLAN_ITEM, OP_STEP, 8'd0, 8'd0, 1'b0, REG_GRID_ROWS, 9'd0, 1'b0, NO_REPORT},
        '{PLAN_ITEM, OP_STEP, 8'd0, 8'd0, 1'b0, REG_GRID_ROWS, 9'd0, 1'b0, NO_REPORT},
        '{PLAN_ITEM, OP_STEP, 8'd0, 8'd0, 1'b0, REG_GRID_ROWS, 9'd0, 1'b0, NO_REPORT},
        '{PLAN_CFG, OP_STEP, 8'd0, 8'd0, 1'b0, REG_GRID_ROWS, 9'd2, 1'b0, NO_REPORT},
        '{PLAN_CFG, OP_STEP, 8'd0, 8'd0, 1'b0, REG_GRID_COLS, 9'd256, 1'b0, NO_REPORT},
        '{PLAN_CFG, OP_STEP, 8'd0, 8'd0, 1'b0, REG_START_ROW, 9'd255, 1'b0, NO_REPORT},
        '{PLAN_CFG, OP_STEP, 8'd0, 8'd0, 1'b0, REG_START_COL, 9'd255, 1'b0, NO_REPORT},
        '{PLAN_CFG, OP_STEP, 8'd0, 8'd0, 1'b0, REG_START_HEADING, 9'd3, 1'b0, NO_REPORT},
        '{PLAN_ITEM, OP_STEP, 8'd0, 8'd0, 1'b0, REG_GRID_ROWS, 9'd0, 1'b0, NO_REPORT},
        '{PLAN_ITEM, OP_STEP, 8'd0, 8'd0, 1'b0, REG_GRID_ROWS, 9'd0, 1'b0, NO_REPORT},
        '{PLAN_ITEM, OP_STEP, 8'd0, 8'd0, 1'b0, REG_GRID_ROWS, 9'd0, 1'b0, NO_REPORT},
        '{PLAN_CFG, OP_STEP, 8'd0, 8'd0, 1'b0, REG_GRID_ROWS, 9'd256, 1'b0, NO_REPORT},
        '{PLAN_CFG, OP_STEP, 8'd0, 8'd0, 1'b0, REG_GRID_COLS, 9'd1, 1'b0, NO_REPORT},
        '{PLAN_CFG, OP_STEP, 8'd0, 8'd0, 1'b0, REG_START_HEADING, 9'd6, 1'b0, NO_REPORT},
        '{PLAN_ITEM, OP_STEP, 8'd0, 8'd0, 1'b0, REG_GRID_ROWS, 9'd0, 1'b0, NO_REPORT},
        '{PLAN_ITEM, OP_STEP, 8'd0, 8'd0, 1'b0, REG_GRID_ROWS, 9'd0, 1'b0, NO_REPORT},
        '{PLAN_ITEM, OP_STEP, 8'd0, 8'd0, 1'b0, REG_GRID_ROWS, 9'd0, 1'b0, NO_REPORT},
        '{PLAN_ITEM, OP_LOAD, 8'd255, 8'd255, 1'b0, REG_GRID_ROWS, 9'd0, 1'b0, NO_REPORT}
    };

    logic               i_clk;
    logic               i_rst_n       = 1'b0;
    logic               start         = 1'b0;
    logic               busy;
    logic               i_op          = OP_STEP;
    logic [COORD_W-1:0] i_load_row    = '0;
    logic [COORD_W-1:0] i_load_col    = '0;
    logic               i_load_colour = 1'b0;
    logic               o_strobe;
    logic [COORD_W-1:0] o_ant_row;
    logic [COORD_W-1:0] o_ant_col;
    logic [HEAD_W-1:0]  o_ant_heading;
    logic               o_colour_seen;
    logic               i_cfg_valid   = 1'b0;
    logic               o_cfg_ready;
    logic [IDX_W-1:0]   i_cfg_index   = '0;
    logic [CFG_W-1:0]   i_cfg_data    = '0;

    logic               grid_model [GRID_MAX_ROWS*GRID_MAX_COLS];
    logic [EXT_W-1:0]   rows_reg;
    logic [EXT_W-1:0]   cols_reg;
    logic [COORD_W-1:0] ant_r;
    logic [COORD_W-1:0] ant_c;
    logic [HEAD_W-1:0]  ant_h;

    t_ant_report pending_reports [$];
    int          mismatch_count = 0;
    int          quiet_cycles   = 0;
    bit          bursts_on      = 1'b1;

    grid_ant_automaton_step_unit #(
        .MAX_ROWS(GRID_MAX_ROWS),
        .MAX_COLS(GRID_MAX_COLS)
    ) u_dut (
        .i_clk         (i_clk),
        .i_rst_n       (i_rst_n),
        .start         (start),
        .busy          (busy),
        .i_op          (i_op),
        .i_load_row    (i_load_row),
        .i_load_col    (i_load_col),
        .i_load_colour (i_load_colour),
        .o_strobe      (o_strobe),
        .o_ant_row     (o_ant_row),
        .o_ant_col     (o_ant_col),
        .o_ant_heading (o_ant_heading),
        .o_colour_seen (o_colour_seen),
        .i_cfg_valid   (i_cfg_valid),
        .o_cfg_ready   (o_cfg_ready),
        .i_cfg_index   (i_cfg_index),
        .i_cfg_data    (i_cfg_data)
    );

    initial begin
        i_clk = 1'b0;
        forever #5 i_clk = ~i_clk;
    end

    function automatic int unsigned clamp_extent(input logic [EXT_W-1:0] value, input int cap);
        int unsigned lim;
        lim = (cap < 256) ? cap : 256;
        if (value == 0)
            return 1;
        return (value > lim) ? lim : value;
    endfunction

    function automatic bit in_store(input logic [COORD_W-1:0] r, input logic [COORD_W-1:0] c);
        return int'(r) < GRID_MAX_ROWS && int'(c) < GRID_MAX_COLS;
    endfunction

    function automatic int cell_index(input logic [COORD_W-1:0] r, input logic [COORD_W-1:0] c);
        return int'(r) * GRID_MAX_COLS + int'(c);
    endfunction

    function automatic t_ant_report predict_ant(input logic op, input logic [COORD_W-1:0] row,
                                                input logic [COORD_W-1:0] col,
                                                input logic colour);
        int unsigned er;
        int unsigned ec;
        logic        seen;
        t_ant_report rep;
        seen = 1'b0;
        if (op == OP_LOAD) begin
            if (in_store(row, col))
                grid_model[cell_index(row, col)] = colour;
        end else begin
            er = clamp_extent(rows_reg, GRID_MAX_ROWS);
            ec = clamp_extent(cols_reg, GRID_MAX_COLS);
            if (in_store(ant_r, ant_c))
                seen = grid_model[cell_index(ant_r, ant_c)];
            ant_h = ant_h + (seen ? TURN_BLACK : TURN_WHITE);
            if (in_store(ant_r, ant_c))
                grid_model[cell_index(ant_r, ant_c)] = !seen;
            case (ant_h)
                HEAD_NE, HEAD_N, HEAD_NW: ant_r = COORD_W'((ant_r + er - 1) % er);
                HEAD_SW, HEAD_S, HEAD_SE: ant_r = COORD_W'((ant_r + 1) % er);
                default: ;
            endcase
            case (ant_h)
                HEAD_E, HEAD_NE, HEAD_SE: ant_c = COORD_W'((ant_c + 1) % ec);
                HEAD_NW, HEAD_WEST, HEAD_SW: ant_c = COORD_W'((ant_c + ec - 1) % ec);
                default: ;
            endcase
        end
        rep.row     = ant_r;
        rep.col     = ant_c;
        rep.heading = ant_h;
        rep.seen    = seen;
        return rep;
    endfunction

    function automatic logic [CFG_W-1:0] pick_extent();
        case ($urandom_range(0, 7))
            0: return '0;
            1: return CFG_W'(1);
            2: return GRID_RESET;
            3: return CFG_W'($urandom_range(257, 511));
            4: return CFG_W'($urandom_range(2, 4));
            default: return CFG_W'($urandom_range(2, 16));
        endcase
    endfunction

    function automatic logic [CFG_W-1:0] pick_start(input logic [EXT_W-1:0] extent_reg,
                                                    input int cap);
        if ($urandom_range(0, 19) < 17)
            return CFG_W'($urandom_range(0, clamp_extent(extent_reg, cap) - 1));
        return CFG_W'($urandom_range(0, 511));
    endfunction

    task automatic hold_off(input int cycles);
        if (start)
            start <= 1'b0;
        if (i_cfg_valid)
            i_cfg_valid <= 1'b0;
        repeat (cycles) @(posedge i_clk);
    endtask

    task automatic wait_quiet();
        hold_off(0);
        while (pending_reports.size() != 0) @(posedge i_clk);
        repeat (SETTLE_CYCLES) @(posedge i_clk);
    endtask

    task automatic maybe_pause(input bit allowed);
        if ($urandom_range(0, 24) == 0)
            bursts_on = !bursts_on;
        if (allowed && bursts_on && $urandom_range(0, 4) == 0)
            hold_off($urandom_range(1, 19));
    endtask

    task automatic write_register(input logic [IDX_W-1:0] idx, input logic [CFG_W-1:0] value);
        if (start)
            start <= 1'b0;
        if (!i_cfg_valid)
            i_cfg_valid <= 1'b1;
        i_cfg_index <= idx;
        i_cfg_data  <= value;
        @(posedge i_clk);
        while (!o_cfg_ready) @(posedge i_clk);
        case (idx)
            REG_GRID_ROWS:     rows_reg = value;
            REG_GRID_COLS:     cols_reg = value;
            REG_START_ROW:     ant_r = value[COORD_W-1:0];
            REG_START_COL:     ant_c = value[COORD_W-1:0];
            REG_START_HEADING: ant_h = value[HEAD_W-1:0];
            default: ;
        endcase
    endtask

    task automatic issue_request(input logic op, input logic [COORD_W-1:0] row,
                                 input logic [COORD_W-1:0] col, input logic colour,
                                 input logic typed, input t_ant_report typed_report);
        t_ant_report predicted;
        if (i_cfg_valid)
            i_cfg_valid <= 1'b0;
        if (!start)
            start <= 1'b1;
        i_op          <= op;
        i_load_row    <= row;
        i_load_col    <= col;
        i_load_colour <= colour;
        @(posedge i_clk);
        while (busy) @(posedge i_clk);
        predicted = predict_ant(op, row, col, colour);
        pending_reports.push_back(typed ? typed_report : predicted);
    endtask

    always @(posedge i_clk) begin
        t_ant_report want;
        if (i_rst_n && o_strobe) begin
            if (pending_reports.size() == 0) begin
                $error("result with no request outstanding: row %0d col %0d heading %0d",
                       o_ant_row, o_ant_col, o_ant_heading);
                mismatch_count++;
            end else begin
                want = pending_reports.pop_front();
                if (o_ant_row !== want.row) begin
                    $error("ant_row: expected %0d, actual %0d", want.row, o_ant_row);
                    mismatch_count++;
                end
                if (o_ant_col !== want.col) begin
                    $error("ant_col: expected %0d, actual %0d", want.col, o_ant_col);
                    mismatch_count++;
                end
                if (o_ant_heading !== want.heading) begin
                    $error("ant_heading: expected %0d, actual %0d", want.heading, o_ant_heading);
                    mismatch_count++;
                end
                if (o_colour_seen !== want.seen) begin
                    $error("colour_seen: expected %0d, actual %0d", want.seen, o_colour_seen);
                    mismatch_count++;
                end
            end
        end
    end

    always @(posedge i_clk) begin
        if ((start && !busy) || o_strobe || (i_cfg_valid && o_cfg_ready))
            quiet_cycles <= 0;
        else
            quiet_cycles <= quiet_cycles + 1;
        if (quiet_cycles >= WATCHDOG_LIMIT) begin
            $display("grid_ant_automaton_step_unit_tb: done, errors");
            $finish;
        end
    end

    initial begin
        logic [COORD_W-1:0] row;
        logic [COORD_W-1:0] col;
        int unsigned        er;
        int unsigned        ec;

        foreach (grid_model[k])
            grid_model[k] = 1'b0;
        rows_reg = GRID_RESET;
        cols_reg = GRID_RESET;
        ant_r    = '0;
        ant_c    = '0;
        ant_h    = HEAD_E;

        repeat (3) @(posedge i_clk);
        i_rst_n <= 1'b1;
        @(posedge i_clk);
        while (busy) @(posedge i_clk);

        foreach (DIRECTED_PLAN[k]) begin
            if (DIRECTED_PLAN[k].kind == PLAN_CFG) begin
                wait_quiet();
                write_register(DIRECTED_PLAN[k].reg_idx, DIRECTED_PLAN[k].reg_data);
            end else begin
                maybe_pause(1'b1);
                issue_request(DIRECTED_PLAN[k].op, DIRECTED_PLAN[k].row, DIRECTED_PLAN[k].col,
                              DIRECTED_PLAN[k].colour, DIRECTED_PLAN[k].typed,
                              DIRECTED_PLAN[k].want);
            end
        end

        for (int phase = 0; phase < PHASES; phase++) begin
            wait_quiet();
            write_register(REG_GRID_ROWS, pick_extent());
            write_register(REG_GRID_COLS, pick_extent());
            write_register(REG_START_ROW, pick_start(rows_reg, GRID_MAX_ROWS));
            write_register(REG_START_COL, pick_start(cols_reg, GRID_MAX_COLS));
            write_register(REG_START_HEADING, CFG_W'($urandom));
            if ($urandom_range(0, 3) == 0)
                write_register(IDX_W'($urandom_range(REG_SPARE_FIRST, REG_SPARE_LAST)),
                               CFG_W'($urandom));
            for (int n = 0; n < ITEMS_PER_PHASE; n++) begin
                maybe_pause(phase < PHASES - 2);
                if (phase < PHASES - 2 && $urandom_range(0, 99) == 0)
                    wait_quiet();
                if ($urandom_range(0, 3) == 0) begin
                    er = clamp_extent(rows_reg, GRID_MAX_ROWS);
                    ec = clamp_extent(cols_reg, GRID_MAX_COLS);
                    row = ($urandom_range(0, 9) < 7) ? COORD_W'($urandom_range(0, er - 1))
                                                     : COORD_W'($urandom);
                    col = ($urandom_range(0, 9) < 7) ? COORD_W'($urandom_range(0, ec - 1))
                                                     : COORD_W'($urandom);
                    issue_request(OP_LOAD, row, col, 1'($urandom), 1'b0, NO_REPORT);
                end else begin
                    issue_request(OP_STEP, COORD_W'($urandom), COORD_W'($urandom),
                                  1'($urandom), 1'b0, NO_REPORT);
                end
            end
        end

        wait_quiet();
        if (mismatch_count == 0 && pending_reports.size() == 0) begin
            $display("grid_ant_automaton_step_unit_tb: done, clean");
        end else begin
            $display("grid_ant_automaton_step_unit_tb: done, errors");
        end
        $finish;
    end

endmodule
